// ===== sv/gis_pkg.sv =====
// Shared types, register codes and divider constants of the gyro init sequencer.
package gis_pkg;

   // Number of samples per average.
   localparam int SAMPLES = 48;

   // The constant divide uses a reciprocal multiply with one correction step.
   // MAG_W holds the largest sum magnitude, Q_W the largest quotient.
   localparam int SUM_W = 23;
   localparam int MAG_W = 22;
   localparam int Q_W = 17;
   localparam int REC_W = 25;
   localparam int DIV_SHIFT = 24;
   localparam int DIV_RECIP = (2 ** DIV_SHIFT) / SAMPLES;
   localparam int PROD_W = MAG_W + REC_W;

   localparam logic [7:0] ADDR_NONE = 8'h00;
   localparam logic [7:0] ADDR_RATE = 8'h15;
   localparam logic [7:0] ADDR_DATA = 8'h1D;
   localparam logic [7:0] ADDR_POWER = 8'h3E;
   localparam logic [7:0] POWER_RESET_VALUE = 8'h00;

   localparam logic [7:0] RATE_DIVIDER_RESET = 8'h00;
   localparam logic [7:0] FILTER_RANGE_RESET = 8'b0000_0011;
   localparam logic [7:0] POWER_CONFIG_RESET = 8'h01;

   localparam logic [2:0] COUNT_NONE = 3'd0;
   localparam logic [2:0] COUNT_ONE = 3'd1;
   localparam logic [2:0] COUNT_TWO = 3'd2;
   localparam logic [2:0] COUNT_READ = 3'd6;

   localparam logic [2:0] PHASE_IDLE = 3'd0;
   localparam logic [2:0] PHASE_RESET = 3'd2;
   localparam logic [2:0] PHASE_RATE = 3'd4;
   localparam logic [2:0] PHASE_RUN = 3'd5;

   typedef enum logic [2:0] {
      CMD_NONE        = 3'd0,
      CMD_BUS_RESET   = 3'd1,
      CMD_READ        = 3'd2,
      CMD_WRITE_RESET = 3'd3,
      CMD_WRITE_RATE  = 3'd4,
      CMD_WRITE_POWER = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      CSR_RATE_DIVIDER     = 2'd0,
      CSR_FILTER_AND_RANGE = 2'd1,
      CSR_POWER_CONFIG     = 2'd2
   } csr_index_type;

   // Command part of one response.
   typedef struct packed {
      command_type command;
      logic [7:0]  reg_address;
      logic [2:0]  byte_count;
      logic [7:0]  write_byte_first;
      logic [7:0]  write_byte_second;
      logic        average_valid;
      logic        sequence_ready;
   } cmd_type;

   // Accumulate controls from the sequencer.
   typedef struct packed {
      logic add_en;
      logic emit;
   } acc_type;

   // Controls that every lane receives.
   typedef struct packed {
      logic add_en;
      logic emit;
      logic load1;
      logic load2;
      logic load3;
   } lane_ctl_type;

endpackage

// ===== sv/gis_channels.sv =====
// Request and response channel interfaces of the gyro init sequencer.
interface gis_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       bus_or_transfer_ok;
   logic [7:0] data_byte_0;
   logic [7:0] data_byte_1;
   logic [7:0] data_byte_2;
   logic [7:0] data_byte_3;
   logic [7:0] data_byte_4;
   logic [7:0] data_byte_5;

   modport source (
      output valid, func, bus_or_transfer_ok,
      output data_byte_0, data_byte_1, data_byte_2, data_byte_3, data_byte_4, data_byte_5,
      input  ready
   );
   modport sink (
      input  valid, func, bus_or_transfer_ok,
      input  data_byte_0, data_byte_1, data_byte_2, data_byte_3, data_byte_4, data_byte_5,
      output ready
   );
endinterface

interface gis_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic [7:0]         reg_address;
   logic [2:0]         byte_count;
   logic [7:0]         write_byte_first;
   logic [7:0]         write_byte_second;
   logic               average_valid;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;
   logic               sequence_ready;

   modport source (
      output valid, command, reg_address, byte_count, write_byte_first, write_byte_second,
      output average_valid, rate_x, rate_y, rate_z, sequence_ready,
      input  ready
   );
   modport sink (
      input  valid, command, reg_address, byte_count, write_byte_first, write_byte_second,
      input  average_valid, rate_x, rate_y, rate_z, sequence_ready,
      output ready
   );
endinterface

// ===== sv/gis_sequencer.sv =====
// Phase sequencer: configuration registers, phase, sample count and command decode.
module gis_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic                accept,
   input  logic                func,
   input  logic                ok,
   output gis_pkg::cmd_type    cmd,
   output gis_pkg::acc_type    acc
);

   logic [7:0] rate_divider_ff;
   logic [7:0] filter_and_range_ff;
   logic [7:0] power_config_ff;
   logic [2:0] phase_ff, phase_in;
   logic [6:0] count_ff, count_in;
   logic [6:0] count_inc;
   logic [2:0] phase_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_divider_ff     <= gis_pkg::RATE_DIVIDER_RESET;
         filter_and_range_ff <= gis_pkg::FILTER_RANGE_RESET;
         power_config_ff     <= gis_pkg::POWER_CONFIG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gis_pkg::CSR_RATE_DIVIDER:     rate_divider_ff <= csr_wdata;
            gis_pkg::CSR_FILTER_AND_RANGE: filter_and_range_ff <= csr_wdata;
            gis_pkg::CSR_POWER_CONFIG:     power_config_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign phase_next = (phase_ff < gis_pkg::PHASE_RUN) ? phase_ff + 3'd1 : gis_pkg::PHASE_RUN;
   assign count_inc  = count_ff + 7'd1;

   always_comb begin
      cmd.command           = gis_pkg::CMD_NONE;
      cmd.reg_address       = gis_pkg::ADDR_NONE;
      cmd.byte_count        = gis_pkg::COUNT_NONE;
      cmd.write_byte_first  = 8'h00;
      cmd.write_byte_second = 8'h00;
      cmd.average_valid     = 1'b0;
      acc.add_en            = 1'b0;
      acc.emit              = 1'b0;
      phase_in              = phase_ff;
      count_in              = count_ff;
      if (!func) begin
         if (!ok) begin
            phase_in    = gis_pkg::PHASE_IDLE;
            cmd.command = gis_pkg::CMD_BUS_RESET;
         end else begin
            phase_in = phase_next;
            unique case (phase_next)
               gis_pkg::PHASE_RESET: begin
                  cmd.command          = gis_pkg::CMD_WRITE_RESET;
                  cmd.reg_address      = gis_pkg::ADDR_POWER;
                  cmd.byte_count       = gis_pkg::COUNT_ONE;
                  cmd.write_byte_first = gis_pkg::POWER_RESET_VALUE;
               end
               gis_pkg::PHASE_RATE: begin
                  cmd.command           = gis_pkg::CMD_WRITE_RATE;
                  cmd.reg_address       = gis_pkg::ADDR_RATE;
                  cmd.byte_count        = gis_pkg::COUNT_TWO;
                  cmd.write_byte_first  = rate_divider_ff;
                  cmd.write_byte_second = filter_and_range_ff;
               end
               default: begin
                  cmd.command     = gis_pkg::CMD_READ;
                  cmd.reg_address = gis_pkg::ADDR_DATA;
                  cmd.byte_count  = gis_pkg::COUNT_READ;
               end
            endcase
         end
      end else if (ok) begin
         if (phase_ff == gis_pkg::PHASE_RATE) begin
            cmd.command          = gis_pkg::CMD_WRITE_POWER;
            cmd.reg_address      = gis_pkg::ADDR_POWER;
            cmd.byte_count       = gis_pkg::COUNT_ONE;
            cmd.write_byte_first = power_config_ff;
         end else if (phase_ff == gis_pkg::PHASE_RUN) begin
            acc.add_en = 1'b1;
            acc.emit   = (count_inc >= 7'(gis_pkg::SAMPLES));
            count_in   = acc.emit ? 7'd0 : count_inc;
         end
      end
      cmd.average_valid  = acc.emit;
      cmd.sequence_ready = (phase_in == gis_pkg::PHASE_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gis_pkg::PHASE_IDLE;
         count_ff <= 7'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/gis_lane.sv =====
// One axis lane: running sum and a three-stage divide by the sample count.
module gis_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  gis_pkg::lane_ctl_type   ctl,
   input  logic [15:0]             word,
   output logic signed [15:0]      rate
);

   logic signed [gis_pkg::SUM_W-1:0]  sum_ff;
   logic signed [gis_pkg::SUM_W-1:0]  sum_in;
   logic signed [gis_pkg::SUM_W-1:0]  mag_full;
   logic [gis_pkg::MAG_W-1:0]         m1_ff, m2_ff;
   logic                              neg1_ff, neg2_ff;
   logic [gis_pkg::PROD_W-1:0]        prod;
   logic [gis_pkg::Q_W-1:0]           q0_ff;
   logic [gis_pkg::MAG_W-1:0]         back_prod;
   logic [gis_pkg::MAG_W-1:0]         remainder;
   logic [gis_pkg::Q_W-1:0]           quot;
   logic signed [15:0]                rate_ff;

   assign sum_in   = sum_ff + {{(gis_pkg::SUM_W - 16){word[15]}}, word};
   assign mag_full = sum_in[gis_pkg::SUM_W-1] ? -sum_in : sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.load1 && ctl.add_en) begin
         sum_ff <= ctl.emit ? '0 : sum_in;
      end
   end

   // A lane that does not emit carries a zero magnitude, so its rate reads zero.
   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         m1_ff   <= ctl.emit ? mag_full[gis_pkg::MAG_W-1:0] : '0;
         neg1_ff <= ctl.emit & sum_in[gis_pkg::SUM_W-1];
      end
   end

   assign prod = gis_pkg::PROD_W'(m1_ff) * gis_pkg::PROD_W'(gis_pkg::DIV_RECIP);

   // The reciprocal is rounded down, so this quotient is exact or one low.
   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         q0_ff   <= prod[gis_pkg::DIV_SHIFT +: gis_pkg::Q_W];
         m2_ff   <= m1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   assign back_prod = gis_pkg::MAG_W'(q0_ff) * gis_pkg::MAG_W'(gis_pkg::SAMPLES);
   assign remainder = m2_ff - back_prod;
   assign quot      = (remainder >= gis_pkg::MAG_W'(gis_pkg::SAMPLES)) ? q0_ff + 1'b1 : q0_ff;

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         rate_ff <= neg2_ff ? 16'(-quot) : quot[15:0];
      end
   end

   assign rate = rate_ff;

endmodule

// ===== sv/gyro_init_sequencer_and_averager.sv =====
// Top level: sequencer, three axis lanes and the merging response stage.
// The block takes one request per clock unless the pipeline is stalled, and returns one
// response per request, in order, through the divide pipeline of each axis
// lane: the sum is taken at acceptance, multiplied by a reciprocal of the sample count in
// the second stage and corrected and signed in the third, which is the output register.
// Requests keep flowing while a response waits, until all three stages hold an item.
// Configuration writes take effect on the next request.
module gyro_init_sequencer_and_averager (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   gis_req_if.sink     req,
   gis_rsp_if.source   rsp
);

   logic                  v1_ff, v2_ff, v3_ff;
   logic                  rdy1, rdy2, rdy3;
   logic                  accept;
   gis_pkg::cmd_type      cmd;
   gis_pkg::acc_type      acc;
   gis_pkg::lane_ctl_type lane_ctl;
   gis_pkg::cmd_type      cmd1_ff, cmd2_ff, cmd3_ff;

   assign rdy3   = !v3_ff || rsp.ready;
   assign rdy2   = !v2_ff || rdy3;
   assign rdy1   = !v1_ff || rdy2;
   assign accept = req.valid && rdy1;
   assign req.ready = rdy1;

   gis_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .func      (req.func),
      .ok        (req.bus_or_transfer_ok),
      .cmd       (cmd),
      .acc       (acc)
   );

   assign lane_ctl.add_en = acc.add_en;
   assign lane_ctl.emit   = acc.emit;
   assign lane_ctl.load1  = accept;
   assign lane_ctl.load2  = v1_ff && rdy2;
   assign lane_ctl.load3  = v2_ff && rdy3;

   // Axes arrive as y, x, z; the x lane takes the second word.
   gis_lane u_lane_x (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .word  ({req.data_byte_2, req.data_byte_3}),
      .rate  (rsp.rate_x)
   );

   gis_lane u_lane_y (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .word  ({req.data_byte_0, req.data_byte_1}),
      .rate  (rsp.rate_y)
   );

   gis_lane u_lane_z (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .word  ({req.data_byte_4, req.data_byte_5}),
      .rate  (rsp.rate_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req.valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctl.load1) begin
         cmd1_ff <= cmd;
      end
      if (lane_ctl.load2) begin
         cmd2_ff <= cmd1_ff;
      end
      if (lane_ctl.load3) begin
         cmd3_ff <= cmd2_ff;
      end
   end

   assign rsp.valid             = v3_ff;
   assign rsp.command           = cmd3_ff.command;
   assign rsp.reg_address       = cmd3_ff.reg_address;
   assign rsp.byte_count        = cmd3_ff.byte_count;
   assign rsp.write_byte_first  = cmd3_ff.write_byte_first;
   assign rsp.write_byte_second = cmd3_ff.write_byte_second;
   assign rsp.average_valid     = cmd3_ff.average_valid;
   assign rsp.sequence_ready    = cmd3_ff.sequence_ready;

   // A bus reset always drops the sequence out of the running phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.sequence_ready |-> rsp.command != gis_pkg::CMD_BUS_RESET)
      else $error("bus reset reported with sequence ready");

   // Averages come only from data completions in the running phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.average_valid |-> rsp.command == gis_pkg::CMD_NONE && rsp.sequence_ready)
      else $error("average reported outside a data completion");

   // The lanes must present zero rates when no average is emitted.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.average_valid |-> rsp.rate_x == 16'sd0 && rsp.rate_y == 16'sd0
                                          && rsp.rate_z == 16'sd0)
      else $error("nonzero rate without an average");

   // An accepted request always enters the first pipeline stage.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted request lost at the first stage");

endmodule
